// File: hw/rtl/cosine_similarity_assert.svh
// Assertion macros for the cosine similarity block.
// Included by the top level; no other dependencies.
`ifndef COSINE_SIMILARITY_ASSERT_SVH
`define COSINE_SIMILARITY_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Implication check under an active-low reset.
`define CS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// A condition that must never hold.
`define CS_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CS_ASSERT(lbl, clk, rst_n, prop, msg)
`define CS_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: hw/rtl/cs_pkg.sv
// Shared constants and controller/datapath types for cosine similarity.
// No dependencies.
package cs_pkg;
	localparam int ELEM_WIDTH = 16;
	localparam int OUT_WIDTH = 16;
	localparam int OUT_FRAC = 15;
	localparam int MAX_LENGTH_DEF = 1024;
	localparam int ROOT_BITS = OUT_FRAC + 1;
	localparam int KW = $clog2(ROOT_BITS);

	typedef struct packed {
		logic acc_en;
		logic start;
		logic mul_step;
		logic root_init;
		logic root_a;
		logic root_b;
		logic out_load;
		logic [KW-1:0] bit_idx;
	} cmd_t;

	typedef struct packed {
		logic zero;
		logic take;
	} status_t;
endpackage

// File: hw/rtl/cs_if.sv
// Valid/ready channel interfaces for element pairs and results.
// Depends on cs_pkg.
interface cs_in_if;
	logic valid;
	logic ready;
	logic signed [cs_pkg::ELEM_WIDTH-1:0] elem_a;
	logic signed [cs_pkg::ELEM_WIDTH-1:0] elem_b;
	logic last;
	modport source (output valid, elem_a, elem_b, last, input ready);
	modport sink (input valid, elem_a, elem_b, last, output ready);
endinterface

interface cs_out_if;
	logic valid;
	logic ready;
	logic signed [cs_pkg::OUT_WIDTH-1:0] similarity;
	logic zero_norm;
	modport source (output valid, similarity, zero_norm, input ready);
	modport sink (input valid, similarity, zero_norm, output ready);
endinterface

// File: hw/rtl/cs_ctrl.sv
// Controller state machine: sequences accumulate, multiply, root search, output.
// Depends on cs_pkg.
module cs_ctrl #(
	parameter int MAX_LENGTH = cs_pkg::MAX_LENGTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  cs_pkg::status_t   status,
	output cs_pkg::cmd_t      cmd
);
	localparam int MB = $clog2(MAX_LENGTH + 1) + 2 * cs_pkg::ELEM_WIDTH - 2;
	localparam int MCW = $clog2(MB);

	typedef enum logic [6:0] {
		S_ACC   = 7'b0000001,
		S_START = 7'b0000010,
		S_MUL   = 7'b0000100,
		S_RI    = 7'b0001000,
		S_RA    = 7'b0010000,
		S_RB    = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [MCW-1:0] cnt_q, cnt_d;
	logic [cs_pkg::KW-1:0] k_q, k_d;
	logic out_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		k_d = k_q;
		cmd = '0;
		cmd.bit_idx = k_q;
		in_ready = 1'b0;
		case (state_q)
			S_ACC: begin
				in_ready = 1'b1;
				cmd.acc_en = in_valid;
				if (in_valid && in_last) state_d = S_START;
			end
			S_START: begin
				cmd.start = 1'b1;
				cnt_d = MCW'(MB - 1);
				state_d = status.zero ? S_DONE : S_MUL;
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) state_d = S_RI;
			end
			S_RI: begin
				cmd.root_init = 1'b1;
				k_d = cs_pkg::KW'(cs_pkg::OUT_FRAC);
				state_d = S_RA;
			end
			S_RA: begin
				cmd.root_a = 1'b1;
				state_d = S_RB;
			end
			S_RB: begin
				cmd.root_b = 1'b1;
				// Accepting the top bit means +1.0: no lower bit can be added.
				if (k_q == '0 || (status.take && k_q == cs_pkg::KW'(cs_pkg::OUT_FRAC))) begin
					state_d = S_DONE;
				end else begin
					k_d = k_q - 1'b1;
					state_d = S_RA;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_ACC;
				end
			end
			default: state_d = S_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACC;
			cnt_q <= '0;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			k_q <= k_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
endmodule

// File: hw/rtl/cs_dp.sv
// Datapath: saturating sums, serial multipliers, bitwise root-quotient search.
// Depends on cs_pkg.
module cs_dp #(
	parameter int MAX_LENGTH = cs_pkg::MAX_LENGTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cs_pkg::cmd_t                         cmd,
	output cs_pkg::status_t                      status,
	input  logic signed [cs_pkg::ELEM_WIDTH-1:0] elem_a,
	input  logic signed [cs_pkg::ELEM_WIDTH-1:0] elem_b,
	output logic signed [cs_pkg::OUT_WIDTH-1:0]  similarity,
	output logic                                 zero_norm
);
	localparam int EW = cs_pkg::ELEM_WIDTH;
	localparam int MB = $clog2(MAX_LENGTH + 1) + 2 * EW - 2;
	localparam int DW = MB + 1;
	localparam int AW = MB + 2;
	localparam int PW = 2 * MB;
	localparam int TW = 2 * MB + 32;
	localparam int SH = 2 * cs_pkg::OUT_FRAC;
	localparam int RB = cs_pkg::ROOT_BITS;
	localparam logic signed [AW-1:0] SUM_MAX = $signed(AW'(MAX_LENGTH) << (2 * EW - 2));
	localparam logic signed [AW-1:0] SUM_MIN = -SUM_MAX;

	logic signed [DW-1:0] dot_q;
	logic [MB-1:0] saa_q, sab_q;
	logic signed [2*EW-1:0] prod_ab, prod_aa, prod_bb;
	logic signed [AW-1:0] dot_nx;
	logic [AW-1:0] saa_nx, sab_nx;
	logic [MB-1:0] mag;

	logic [PW-1:0] pma_q, mma_q, p_q, msq_q;
	logic [MB-1:0] pmb_q, mmb_q;
	logic [TW-1:0] t_q, us_q, ps2_q, part_q, cand, rhs;
	logic [RB-1:0] q_q;
	logic neg_q, zn_q;
	logic signed [cs_pkg::OUT_WIDTH-1:0] sim_q;
	logic zn_out_q;

	assign prod_ab = elem_a * elem_b;
	assign prod_aa = elem_a * elem_a;
	assign prod_bb = elem_b * elem_b;
	assign dot_nx = AW'(dot_q) + AW'(prod_ab);
	assign saa_nx = AW'(saa_q) + AW'($unsigned(prod_aa));
	assign sab_nx = AW'(sab_q) + AW'($unsigned(prod_bb));
	assign mag = dot_q[DW-1] ? MB'(-dot_q) : MB'(dot_q);

	assign cand = part_q + ps2_q;
	assign rhs = TW'(msq_q) << SH;
	assign status.take = (cand <= rhs);
	assign status.zero = (saa_q == '0) || (sab_q == '0);

	// Sums saturate at the length bound and clear once a vector's result starts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			saa_q <= '0;
			sab_q <= '0;
		end else if (cmd.start) begin
			dot_q <= '0;
			saa_q <= '0;
			sab_q <= '0;
		end else if (cmd.acc_en) begin
			if (dot_nx > SUM_MAX) dot_q <= DW'(SUM_MAX);
			else if (dot_nx < SUM_MIN) dot_q <= DW'(SUM_MIN);
			else dot_q <= DW'(dot_nx);
			saa_q <= (saa_nx > $unsigned(SUM_MAX)) ? MB'(SUM_MAX) : MB'(saa_nx);
			sab_q <= (sab_nx > $unsigned(SUM_MAX)) ? MB'(SUM_MAX) : MB'(sab_nx);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			zn_q <= status.zero;
			neg_q <= dot_q[DW-1] && !status.zero;
			q_q <= '0;
			pma_q <= PW'(saa_q);
			pmb_q <= sab_q;
			mma_q <= PW'(mag);
			mmb_q <= mag;
			p_q <= '0;
			msq_q <= '0;
		end
		if (cmd.mul_step) begin
			if (pmb_q[0]) p_q <= p_q + pma_q;
			if (mmb_q[0]) msq_q <= msq_q + mma_q;
			pma_q <= pma_q << 1;
			pmb_q <= pmb_q >> 1;
			mma_q <= mma_q << 1;
			mmb_q <= mmb_q >> 1;
		end
		// t holds q^2*P, us holds q*P shifted to the next bit, ps2 holds P*4^k.
		if (cmd.root_init) begin
			t_q <= '0;
			us_q <= '0;
			ps2_q <= TW'(p_q) << SH;
		end
		if (cmd.root_a) part_q <= t_q + us_q;
		if (cmd.root_b) begin
			if (status.take) begin
				t_q <= cand;
				q_q[cmd.bit_idx] <= 1'b1;
				us_q <= (us_q + (ps2_q << 1)) >> 1;
			end else begin
				us_q <= us_q >> 1;
			end
			ps2_q <= ps2_q >> 2;
		end
		if (cmd.out_load) begin
			zn_out_q <= zn_q;
			if (neg_q) sim_q <= cs_pkg::OUT_WIDTH'(-q_q);
			else if (q_q[RB-1]) sim_q <= {1'b0, {(cs_pkg::OUT_WIDTH-1){1'b1}}};
			else sim_q <= cs_pkg::OUT_WIDTH'(q_q);
		end
	end

	assign similarity = sim_q;
	assign zero_norm = zn_out_q;
endmodule

// File: hw/rtl/cosine_similarity.sv
// Cosine similarity of two streamed Q1.15 vectors, one element pair per cycle while
// accumulating. After the last item the input is held off until the result is loaded:
// start, W multiply steps (W = sum width, 41 at the default length), setup, an RA and
// an RB state for each of 16 quotient bits, and the output load. A zero norm skips the
// multiply and root steps; an exact +/-1.0 stops after the first quotient bit.
// Reset (arst_n, asynchronous, active low) clears the sums and the controller.
`include "cosine_similarity_assert.svh"
module cosine_similarity #(
	parameter int MAX_LENGTH = cs_pkg::MAX_LENGTH_DEF
) (
	input logic clk,
	input logic arst_n,
	cs_in_if.sink elems,
	cs_out_if.source result
);
	// The controller only issues commands; all arithmetic state is in the datapath.
	cs_pkg::cmd_t cmd;
	cs_pkg::status_t status;

	cs_ctrl #(.MAX_LENGTH(MAX_LENGTH)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(elems.valid),
		.in_last(elems.last),
		.in_ready(elems.ready),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.status(status),
		.cmd(cmd)
	);

	// Datapath: sums accumulate per item; at the end the norm product and the
	// squared dot product are formed serially, then the quotient is found bit by
	// bit from the top, comparing q^2*|A|^2*|B|^2 against dot^2 scaled by 2^30.
	cs_dp #(.MAX_LENGTH(MAX_LENGTH)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.elem_a(elems.elem_a),
		.elem_b(elems.elem_b),
		.similarity(result.similarity),
		.zero_norm(result.zero_norm)
	);

	// A zero-norm result always carries a zero similarity.
	`CS_ASSERT(a_zero_norm_sim, clk, arst_n, result.valid && result.zero_norm |-> result.similarity == '0, "zero norm with nonzero similarity")
	// The block stops taking items right after the last one of a vector.
	`CS_ASSERT(a_busy_after_last, clk, arst_n, elems.valid && elems.ready && elems.last |=> !elems.ready, "item taken during result computation")
endmodule
